FILE: rtl/core/rcpwm_pkg.sv
// ----------------------------------------------------------------------------
// rcpwm_pkg: shared types and constants for the RC PWM capture block
// Field types, configuration register indexes and register reset values.
// ----------------------------------------------------------------------------
package rcpwm_pkg;

	// payload field types
	typedef logic [1:0]  chan_t;
	typedef logic [31:0] stamp_t;
	typedef logic [15:0] word_t;
	typedef logic [3:0]  gain_t;

	// configuration port
	typedef logic [7:0]  cfg_idx_t;
	typedef logic [15:0] cfg_data_t;

	localparam cfg_idx_t REG_CEILING = 8'd0;
	localparam cfg_idx_t REG_FLOOR   = 8'd1;
	localparam cfg_idx_t REG_BASE    = 8'd2;
	localparam cfg_idx_t REG_GAIN    = 8'd3;

	// register reset values
	localparam word_t RST_CEILING = 16'd2000;
	localparam word_t RST_FLOOR   = 16'd1500;
	localparam word_t RST_BASE    = 16'd1000;
	localparam gain_t RST_GAIN    = 4'd2;

	localparam word_t THROTTLE_MAX = 16'hFFFF;

endpackage

FILE: rtl/core/rcpwm_ifs.sv
// ----------------------------------------------------------------------------
// rcpwm_ifs: valid/ready channels of the RC PWM capture block
// Capture event channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface rcpwm_cap_if;
	import rcpwm_pkg::*;
	logic   valid;
	logic   ready;
	chan_t  channel;
	stamp_t capture_time;
	modport source (output valid, output channel, output capture_time, input ready);
	modport sink   (input valid, input channel, input capture_time, output ready);
endinterface

interface rcpwm_res_if;
	import rcpwm_pkg::*;
	logic  valid;
	logic  ready;
	chan_t out_channel;
	word_t pulse_width;
	word_t throttle;
	modport source (output valid, output out_channel, output pulse_width,
		output throttle, input ready);
	modport sink   (input valid, input out_channel, input pulse_width,
		input throttle, output ready);
endinterface

interface rcpwm_cfg_if;
	import rcpwm_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/rc_pwm_capture_throttle_map.sv
// ----------------------------------------------------------------------------
// rc_pwm_capture_throttle_map: RC PWM pulse-width capture with throttle map
//
//   channel  dir  payload                                  beat taken when
//   cap      in   channel, capture_time                    valid && ready
//   res      out  out_channel, pulse_width, throttle       valid && ready
//   cfg      in   index, data (always ready)               valid && ready
//
// One beat per cycle on cap unless the input stage is stalled. A beat is
// registered in the input stage, where the per-channel armed flag and rise
// stamp are read and updated, and the width and throttle are computed into
// the result register, which drives res. The result register stalls the
// input stage only when the beat there completes a pulse. Reset clears
// armed flags and valids and loads the config regs with their defaults.
// ----------------------------------------------------------------------------
module rc_pwm_capture_throttle_map #(
	parameter int NUM_CHANNELS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	rcpwm_cap_if.sink        cap,
	rcpwm_res_if.source      res,
	rcpwm_cfg_if.sink        cfg
);
	import rcpwm_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// configuration registers
	word_t ceiling_q, floor_q, base_q;
	gain_t gain_q;

	// input stage
	logic   valid_s1;
	chan_t  chan_s1;
	word_t  time_s1;

	// per-channel state
	logic [NUM_CHANNELS-1:0] armed_q;
	word_t                   rise_q [NUM_CHANNELS];

	// result register
	logic  out_valid_q;
	chan_t out_chan_q;
	word_t out_width_q, out_thr_q;

	logic            in_range, emit, out_free, adv_s1, fire_s1;
	logic [CH_W-1:0] idx_s1;
	word_t           width, diff, throttle;
	logic [19:0]     prod;
	logic [20:0]     lin;

	// take config writes at any time
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= RST_CEILING;
			floor_q   <= RST_FLOOR;
			base_q    <= RST_BASE;
			gain_q    <= RST_GAIN;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CEILING: ceiling_q <= cfg.data;
				REG_FLOOR:   floor_q   <= cfg.data;
				REG_BASE:    base_q    <= cfg.data;
				REG_GAIN:    gain_q    <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// stage control: block only when a completing beat meets a full result reg
	assign idx_s1   = CH_W'(chan_s1);
	assign in_range = (32'(chan_s1) < NUM_CHANNELS);
	assign emit     = valid_s1 && in_range && armed_q[idx_s1];
	assign out_free = !out_valid_q || res.ready;
	assign adv_s1   = !emit || out_free;
	assign fire_s1  = valid_s1 && adv_s1;
	assign cap.ready = !valid_s1 || adv_s1;

	// capture the incoming beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cap.ready) begin
			valid_s1 <= cap.valid;
		end
	end

	// only the low half of the stamp matters for a 16-bit width
	always_ff @(posedge clk) begin
		if (cap.ready && cap.valid) begin
			chan_s1 <= cap.channel;
			time_s1 <= cap.capture_time[15:0];
		end
	end

	// width and throttle mapping
	always_comb begin
		width = time_s1 - rise_q[idx_s1];
		diff  = width - floor_q;
		prod  = 20'(diff) * 20'(gain_q);
		lin   = 21'(prod) + 21'(base_q);
		if (width > ceiling_q) begin
			throttle = ceiling_q;
		end else if (width < floor_q) begin
			throttle = base_q;
		end else if (lin > 21'(THROTTLE_MAX)) begin
			throttle = THROTTLE_MAX;
		end else begin
			throttle = lin[15:0];
		end
	end

	// toggle armed flag on each in-range beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (fire_s1 && in_range) begin
			armed_q[idx_s1] <= !armed_q[idx_s1];
		end
	end

	// store rise stamp when arming
	always_ff @(posedge clk) begin
		if (fire_s1 && in_range && !armed_q[idx_s1]) begin
			rise_q[idx_s1] <= time_s1;
		end
	end

	// result register: load on completing beat, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			out_chan_q  <= chan_s1;
			out_width_q <= width;
			out_thr_q   <= throttle;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.out_channel = out_chan_q;
	assign res.pulse_width = out_width_q;
	assign res.throttle    = out_thr_q;

	// checks
	a_oob_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && !in_range) |=> $stable(armed_q))
		else $error("out-of-range channel changed armed flags");

	a_armed_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && in_range) |=> (armed_q[$past(idx_s1)] != $past(armed_q[idx_s1])))
		else $error("armed flag did not toggle");

	a_ceiling_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_width_q > ceiling_q)) |-> (out_thr_q == ceiling_q))
		else $error("width above ceiling not clamped");

	a_floor_base: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_width_q <= ceiling_q) && (out_width_q < floor_q))
		|-> (out_thr_q == base_q))
		else $error("width below floor did not give base");

endmodule
